### design/pidhtc_pkg.sv
`timescale 1ns / 1ps

package pidhtc_pkg;

  // heading and speed constants, 1/16 degree and Q2.14
  localparam int HALF_TURN    = 2880;
  localparam int FULL_TURN    = 5760;
  localparam int INTEG_WINDOW = 800;
  localparam int FLOOR_MIN    = 2867;
  localparam int FULL_SPEED   = 16384;

  // configuration register reset values
  localparam logic [11:0] TOL_RESET   = 12'd32;
  localparam logic [14:0] CEIL_RESET  = 15'd16384;
  localparam logic [14:0] FLOOR_RESET = 15'd2867;

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_START  = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    CFG_PROP_GAIN   = 3'd0,
    CFG_INTEG_GAIN  = 3'd1,
    CFG_DERIV_GAIN  = 3'd2,
    CFG_SETTLE_TOL  = 3'd3,
    CFG_SPEED_CEIL  = 3'd4,
    CFG_SPEED_FLOOR = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    opcode_t            opcode;
    logic signed [15:0] heading;
    logic signed [15:0] target_angle;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] drive_speed;
    logic               done_res;
  } result_t;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [15:0] deriv_gain;
    logic [11:0] settle_tolerance;
    logic [14:0] speed_ceiling;
    logic [14:0] speed_floor;
  } cfg_t;

  // step stage result: error terms for the products
  typedef struct packed {
    logic               done;
    logic signed [23:0] err;
    logic signed [31:0] accum;
    logic signed [24:0] deriv;
  } step_t;

  // product stage result
  typedef struct packed {
    logic               done;
    logic signed [40:0] p_prop;
    logic signed [48:0] p_integ;
    logic signed [41:0] p_deriv;
  } prod_t;

  function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
    logic signed [23:0] r;
    if (v[24] != v[23]) begin
      r = v[24] ? 24'sh800000 : 24'sh7FFFFF;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### design/pid_heading_turn_controller.sv
`timescale 1ns / 1ps
// path: an accepted request moves from the input register through the step register
// and the product register to the result register, where its result becomes valid
// throughput: one request per cycle while result_stall is low; the state recurrence closes in the step stage
// reset: synchronous rst clears all valids, the controller state and sets the
// configuration registers to their defaults

module pid_heading_turn_controller import pidhtc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  sample_t     sample,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t  cfg;
  logic  step_valid;
  step_t step;
  logic  step_ready;
  logic  prod_valid;
  prod_t prod;
  logic  mult_ready;
  logic  out_ready;

  // configuration registers
  pidhtc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register and state update
  pidhtc_step u_step (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample       (sample),
    .sample_stall (sample_stall),
    .take         (mult_ready),
    .ready        (step_ready),
    .step_valid   (step_valid),
    .step         (step)
  );

  // gain products
  pidhtc_mult u_mult (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step_valid (step_valid),
    .step       (step),
    .take       (out_ready),
    .ready      (mult_ready),
    .prod_valid (prod_valid),
    .prod       (prod)
  );

  // sum, clamp and result register
  pidhtc_out u_out (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .prod_valid   (prod_valid),
    .prod         (prod),
    .ready        (out_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // a settled result always commands zero speed
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.done_res |-> result.drive_speed == 16'sd0)
    else $error("settled result with nonzero speed");

  // speed never leaves full scale
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.drive_speed <= 16'sd16384) && (result.drive_speed >= -16'sd16384))
    else $error("drive speed beyond full scale");

  // a blocked step register keeps its request
  assert property (@(posedge clk) disable iff (rst)
    step_valid && !mult_ready |=> step_valid && $stable(step))
    else $error("step register lost a blocked request");

  // a blocked product register keeps its request
  assert property (@(posedge clk) disable iff (rst)
    prod_valid && !out_ready |=> prod_valid && $stable(prod))
    else $error("product register lost a blocked request");

  // the input side stalls only when the step register cannot move
  assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> step_valid && !step_ready)
    else $error("input stalled while step stage was free");

endmodule

### design/pidhtc_cfg.sv
`timescale 1ns / 1ps

module pidhtc_cfg import pidhtc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  // register file; the user must write it only while the block is idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain        <= '0;
      cfg.integ_gain       <= '0;
      cfg.deriv_gain       <= '0;
      cfg.settle_tolerance <= TOL_RESET;
      cfg.speed_ceiling    <= CEIL_RESET;
      cfg.speed_floor      <= FLOOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PROP_GAIN:   cfg.prop_gain        <= cfg_data;
        CFG_INTEG_GAIN:  cfg.integ_gain       <= cfg_data;
        CFG_DERIV_GAIN:  cfg.deriv_gain       <= cfg_data;
        CFG_SETTLE_TOL:  cfg.settle_tolerance <= cfg_data[11:0];
        CFG_SPEED_CEIL:  cfg.speed_ceiling    <= cfg_data[14:0];
        CFG_SPEED_FLOOR: cfg.speed_floor      <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

endmodule

### design/pidhtc_step.sv
`timescale 1ns / 1ps

module pidhtc_step import pidhtc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    sample_valid,
  input  sample_t sample,
  output logic    sample_stall,
  input  logic    take,
  output logic    ready,
  output logic    step_valid,
  output step_t   step
);

  // input register
  logic    in_valid;
  sample_t in_q;
  logic    in_ready;
  logic    adv;

  // controller state; the oldest error needed is hist_b (it becomes the third entry)
  logic signed [23:0] goal;
  logic signed [15:0] prev_heading;
  logic signed [23:0] prev_error;
  logic signed [23:0] hist_a;
  logic signed [23:0] hist_b;
  logic [1:0]         hist_fill;
  logic signed [31:0] accum;
  logic               settled;

  // state after an optional start
  logic signed [23:0] g0;
  logic signed [15:0] ph0;
  logic signed [23:0] pe0;
  logic signed [23:0] ha0;
  logic signed [23:0] hb0;
  logic [1:0]         fill0;
  logic signed [31:0] acc0;
  logic               set0;
  logic signed [16:0] start_err;

  // step results
  logic signed [17:0] hd18;
  logic signed [17:0] ph18;
  logic signed [23:0] hd24;
  logic signed [23:0] ph24;
  logic signed [23:0] goal_next;
  logic signed [23:0] err;
  logic signed [24:0] deriv;
  logic [23:0]        err_mag;
  logic signed [24:0] settle_diff;
  logic [24:0]        settle_mag;
  logic signed [31:0] accum_next;
  logic               settle_hit;
  logic [1:0]         fill_next;

  // handshake chain
  assign ready        = !step_valid || take;
  assign in_ready     = !in_valid || ready;
  assign sample_stall = !in_ready;
  assign adv          = in_valid && ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && sample_valid) begin
      in_q <= sample;
    end
  end

  // start request loads target and clears history
  always_comb begin
    start_err = {in_q.target_angle[15], in_q.target_angle}
              - {in_q.heading[15], in_q.heading};
    if (in_q.opcode == OP_START) begin
      g0    = {{8{in_q.target_angle[15]}}, in_q.target_angle};
      ph0   = in_q.heading;
      pe0   = {{7{start_err[16]}}, start_err};
      ha0   = '0;
      hb0   = '0;
      fill0 = '0;
      acc0  = '0;
      set0  = 1'b0;
    end else begin
      g0    = goal;
      ph0   = prev_heading;
      pe0   = prev_error;
      ha0   = hist_a;
      hb0   = hist_b;
      fill0 = hist_fill;
      acc0  = accum;
      set0  = settled;
    end
  end

  // goal wrap, error, derivative, integral and settle test
  always_comb begin
    hd18 = {{2{in_q.heading[15]}}, in_q.heading};
    ph18 = {{2{ph0[15]}}, ph0};
    hd24 = {{8{in_q.heading[15]}}, in_q.heading};
    ph24 = {{8{ph0[15]}}, ph0};

    if ((hd18 + 18'(HALF_TURN) < ph18) && (g0 > ph24)) begin
      goal_next = sat24({g0[23], g0} - 25'(FULL_TURN));
    end else if ((hd18 - 18'(HALF_TURN) > ph18) && (g0 < ph24)) begin
      goal_next = sat24({g0[23], g0} + 25'(FULL_TURN));
    end else begin
      goal_next = g0;
    end

    err     = sat24({goal_next[23], goal_next} - {hd24[23], hd24});
    deriv   = {pe0[23], pe0} - {err[23], err};
    err_mag = err[23] ? 24'(-err) : 24'(err);

    if (cfg.integ_gain == '0) begin
      accum_next = acc0;
    end else if (err_mag < 24'(INTEG_WINDOW)) begin
      accum_next = sat32({acc0[31], acc0} + {{9{err[23]}}, err});
    end else begin
      accum_next = '0;
    end

    fill_next   = (fill0 == 2'd3) ? fill0 : fill0 + 2'd1;
    settle_diff = {hb0[23], hb0} - {err[23], err};
    settle_mag  = settle_diff[24] ? 25'(-settle_diff) : 25'(settle_diff);
    settle_hit  = (fill0 >= 2'd2)
               && (settle_mag <= {13'b0, cfg.settle_tolerance})
               && (err_mag <= {11'b0, cfg.settle_tolerance, 1'b0});
  end

  // state update, once per request leaving the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      goal         <= '0;
      prev_heading <= '0;
      prev_error   <= '0;
      hist_a       <= '0;
      hist_b       <= '0;
      hist_fill    <= '0;
      accum        <= '0;
      settled      <= 1'b0;
    end else if (adv) begin
      if (set0) begin
        goal         <= g0;
        prev_heading <= ph0;
        prev_error   <= pe0;
        hist_a       <= ha0;
        hist_b       <= hb0;
        hist_fill    <= fill0;
        accum        <= acc0;
        settled      <= 1'b1;
      end else begin
        goal         <= goal_next;
        prev_heading <= in_q.heading;
        prev_error   <= err;
        hist_a       <= pe0;
        hist_b       <= ha0;
        hist_fill    <= fill_next;
        accum        <= accum_next;
        settled      <= settle_hit;
      end
    end
  end

  // step output register
  always_ff @(posedge clk) begin
    if (rst) begin
      step_valid <= 1'b0;
    end else if (ready) begin
      step_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      step.done  <= set0 || settle_hit;
      step.err   <= err;
      step.accum <= accum_next;
      step.deriv <= deriv;
    end
  end

endmodule

### design/pidhtc_mult.sv
`timescale 1ns / 1ps

module pidhtc_mult import pidhtc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  step_valid,
  input  step_t step,
  input  logic  take,
  output logic  ready,
  output logic  prod_valid,
  output prod_t prod
);

  logic signed [16:0] kp;
  logic signed [16:0] ki;
  logic signed [16:0] kd;

  assign ready = !prod_valid || take;

  // gains are unsigned Q8.8, widened to signed operands
  assign kp = $signed({1'b0, cfg.prop_gain});
  assign ki = $signed({1'b0, cfg.integ_gain});
  assign kd = $signed({1'b0, cfg.deriv_gain});

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (ready) begin
      prod_valid <= step_valid;
    end
  end

  // three parallel products
  always_ff @(posedge clk) begin
    if (ready && step_valid) begin
      prod.done    <= step.done;
      prod.p_prop  <= step.err * kp;
      prod.p_integ <= step.accum * ki;
      prod.p_deriv <= step.deriv * kd;
    end
  end

endmodule

### design/pidhtc_out.sv
`timescale 1ns / 1ps

module pidhtc_out import pidhtc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    prod_valid,
  input  prod_t   prod,
  output logic    ready,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic signed [49:0] sum;
  logic signed [41:0] quot;
  logic signed [41:0] lim;
  logic [14:0]        ceil_v;
  logic [14:0]        floor_v;
  logic signed [41:0] ceil_s;
  logic signed [41:0] floor_s;
  logic signed [15:0] speed;

  assign ready = !result_valid || !result_stall;

  // pid sum, floor divide by 256, clamp, minimum push and zero speed when done
  always_comb begin
    sum  = {{9{prod.p_prop[40]}}, prod.p_prop}
         + {{1{prod.p_integ[48]}}, prod.p_integ}
         + {{8{prod.p_deriv[41]}}, prod.p_deriv};
    quot = sum[49:8];

    ceil_v = (cfg.speed_ceiling > 15'(FULL_SPEED)) ? 15'(FULL_SPEED) : cfg.speed_ceiling;
    if (cfg.speed_floor < 15'(FLOOR_MIN)) begin
      floor_v = 15'(FLOOR_MIN);
    end else if (cfg.speed_floor > 15'(FULL_SPEED)) begin
      floor_v = 15'(FULL_SPEED);
    end else begin
      floor_v = cfg.speed_floor;
    end
    ceil_s  = $signed({27'b0, ceil_v});
    floor_s = $signed({27'b0, floor_v});

    lim = quot;
    if (lim > ceil_s) begin
      lim = ceil_s;
    end
    if (lim < -ceil_s) begin
      lim = -ceil_s;
    end
    if (lim > 42'sd0 && lim < floor_s) begin
      lim = floor_s;
    end
    if (lim < 42'sd0 && lim > -floor_s) begin
      lim = -floor_s;
    end

    speed = prod.done ? 16'sd0 : lim[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready) begin
      result_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && prod_valid) begin
      result.drive_speed <= speed;
      result.done_res    <= prod.done;
    end
  end

endmodule
